/* design/dtp_pkg.sv */
package dtp_pkg;

  localparam int unsigned MAX_ELEMENTS = 4096;
  localparam int unsigned CNT_W        = 13;
  localparam int unsigned DBL_W        = 64;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned TOT_W        = 16;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIVE_BYTE_MODE = 1'b0,
    REG_ELEMENT_COUNT  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [WORD_W-1:0] packed_word;
    logic              end_of_item;
    logic              end_of_buffer;
    logic [TOT_W-1:0]  byte_total;
  } res_word_t;

  typedef struct packed {
    logic [CNT_W-1:0]  item_position;
    logic [WORD_W-1:0] collect_word;
    logic [TOT_W-1:0]  bytes_emitted;
  } pack_state_t;

  typedef struct packed {
    res_word_t   w0;
    res_word_t   w1;
    logic        two_words;
    pack_state_t state_nxt;
  } gen_result_t;

endpackage

/* design/dtp_if.sv */
interface dtp_in_if;
  import dtp_pkg::*;
  logic             valid;
  logic             ready;
  logic [DBL_W-1:0] double_bits;

  modport source (output valid, output double_bits, input ready);
  modport sink (input valid, input double_bits, output ready);
endinterface

interface dtp_out_if;
  import dtp_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] packed_word;
  logic              end_of_item;
  logic              end_of_buffer;
  logic [TOT_W-1:0]  byte_total;

  modport source (output valid, output packed_word, output end_of_item,
                  output end_of_buffer, output byte_total, input ready);
  modport sink (input valid, input packed_word, input end_of_item,
                input end_of_buffer, input byte_total, output ready);
endinterface

/* design/dtp_word_gen.sv */
module dtp_word_gen import dtp_pkg::*; (
  input  logic [DBL_W-1:0] double_bits,
  input  logic             five_byte_mode,
  input  logic [CNT_W-1:0] element_count,
  input  pack_state_t      state,
  output gen_result_t      result
);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  full;
  logic              last;
  logic              tail;
  logic [1:0]        slot;
  logic              group_end;
  logic [WORD_W-1:0] hi;
  logic [WORD_W-1:0] lo;
  logic [WORD_W-1:0] field;
  logic [WORD_W-1:0] collect_nxt;
  logic [TOT_W-1:0]  bytes4;
  logic [TOT_W-1:0]  bytes8;

  always_comb begin
    hi = double_bits[DBL_W-1:WORD_W];
    lo = double_bits[WORD_W-1:0];

    if (element_count == '0) begin
      count = CNT_W'(1);
    end else if (element_count > CNT_W'(MAX_ELEMENTS)) begin
      count = CNT_W'(MAX_ELEMENTS);
    end else begin
      count = element_count;
    end

    full = five_byte_mode ? {count[CNT_W-1:2], 2'b00} : {count[CNT_W-1:1], 1'b0};
    last = ({1'b0, state.item_position} + (CNT_W+1)'(1)) >= {1'b0, count};
    tail = state.item_position >= full;
    slot = five_byte_mode ? state.item_position[1:0] : {1'b0, state.item_position[0]};
    group_end = five_byte_mode ? (slot == 2'd3) : slot[0];

    if (five_byte_mode) begin
      field = {lo[31:24], 24'd0} >> {slot, 3'b000};
    end else begin
      field = slot[0] ? {16'd0, lo[31:16]} : {lo[31:16], 16'd0};
    end
    collect_nxt = (slot == 2'd0) ? field : (state.collect_word | field);

    bytes4 = state.bytes_emitted + TOT_W'(4);
    bytes8 = state.bytes_emitted + TOT_W'(8);

    result = '0;
    result.two_words = tail | group_end;
    if (tail) begin
      result.w0.packed_word   = lo;
      result.w1.packed_word   = hi;
      result.w1.end_of_item   = 1'b1;
      result.w1.end_of_buffer = last;
      result.w1.byte_total    = last ? bytes8 : '0;
    end else if (group_end) begin
      result.w0.packed_word   = hi;
      result.w1.packed_word   = collect_nxt;
      result.w1.end_of_item   = 1'b1;
      result.w1.end_of_buffer = last;
      result.w1.byte_total    = last ? bytes8 : '0;
    end else begin
      result.w0.packed_word   = hi;
      result.w0.end_of_item   = 1'b1;
      result.w0.end_of_buffer = last;
      result.w0.byte_total    = last ? bytes4 : '0;
    end

    if (last) begin
      result.state_nxt = '0;
    end else begin
      result.state_nxt.item_position = state.item_position + CNT_W'(1);
      result.state_nxt.collect_word  = tail ? state.collect_word : collect_nxt;
      result.state_nxt.bytes_emitted = result.two_words ? bytes8 : bytes4;
    end
  end

endmodule

/* design/double_truncating_packer.sv */
// Packs a buffer of IEEE doubles into a stream of 32-bit words, truncating
// low mantissa bits. The input channel takes one double per word; the output
// channel gives packed words with end-of-item and end-of-buffer flags, and
// the byte total of the buffer on its final word.
// The configuration port writes the mode bit (index 0) and the element count
// (index 1); the user must write it only while no buffer is in progress, as
// the block itself does not enforce this. An accepted double is turned into
// its one or two output words in the same cycle and held in a two-entry
// output register, so the first word appears in the cycle after acceptance.
// A double that yields one word can be followed by the next in every cycle
// while the receiver is ready; a double at the end of a group or in the tail
// yields two words, and the next double waits until the first has been taken.
// A new double is taken while the last pending word is being delivered.
// When the receiver stalls, the pending words hold and input ready drops as
// soon as a second word would be waiting.
// Synchronous reset clears the buffer position, the collect word, the byte
// count and the output fill count, and restores 6-byte mode with a count of 1.
module double_truncating_packer import dtp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  dtp_in_if.sink                in_ch,
  dtp_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic             five_byte_mode_r;
  logic [CNT_W-1:0] element_count_r;
  pack_state_t      state_r;
  res_word_t        head_r;
  res_word_t        second_r;
  logic [1:0]       cnt_r;
  logic [1:0]       cnt_nxt;
  gen_result_t      gen;
  logic             in_take;
  logic             out_pop;

  dtp_word_gen u_word_gen (
    .double_bits   (in_ch.double_bits),
    .five_byte_mode(five_byte_mode_r),
    .element_count (element_count_r),
    .state         (state_r),
    .result        (gen)
  );

  assign out_pop      = (cnt_r != 2'd0) && out_ch.ready;
  assign in_ch.ready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready);
  assign in_take      = in_ch.valid && in_ch.ready;

  assign out_ch.valid         = cnt_r != 2'd0;
  assign out_ch.packed_word   = head_r.packed_word;
  assign out_ch.end_of_item   = head_r.end_of_item;
  assign out_ch.end_of_buffer = head_r.end_of_buffer;
  assign out_ch.byte_total    = head_r.byte_total;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_take) begin
      cnt_nxt = gen.two_words ? 2'd2 : 2'd1;
    end else if (out_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      five_byte_mode_r <= 1'b0;
      element_count_r  <= CNT_W'(1);
      state_r          <= '0;
      cnt_r            <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_take) begin
        state_r <= gen.state_nxt;
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_FIVE_BYTE_MODE: five_byte_mode_r <= cfg_data[0];
          REG_ELEMENT_COUNT:  element_count_r  <= cfg_data[CNT_W-1:0];
          default:            element_count_r  <= element_count_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      head_r   <= gen.w0;
      second_r <= gen.w1;
    end else if (out_pop) begin
      head_r <= second_r;
    end
  end

endmodule

/* design/dtp_checker.sv */
module dtp_checker import dtp_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [WORD_W-1:0] packed_word,
  input logic             end_of_item,
  input logic             end_of_buffer,
  input logic [TOT_W-1:0] byte_total
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(packed_word))
    else $error("stalled output word changed");

  a_eob_eoi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && end_of_buffer |-> end_of_item && (byte_total[1:0] == 2'b00))
    else $error("bad end of buffer word");

  a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !end_of_buffer |-> byte_total == '0)
    else $error("byte total set before end of buffer");

  a_no_take_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && !out_ready && out_valid |=> $past(!end_of_item) || !out_valid ||
      $past(in_valid))
    else $error("input taken over a pending word");

endmodule

bind double_truncating_packer dtp_checker u_dtp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .packed_word  (out_ch.packed_word),
  .end_of_item  (out_ch.end_of_item),
  .end_of_buffer(out_ch.end_of_buffer),
  .byte_total   (out_ch.byte_total)
);
